// ----- design/lbp_pkg.sv -----
package lbp_pkg;

    localparam int LBP_PIX_W       = 8;
    localparam int LBP_CODE_W      = 8;
    localparam int LBP_WIDTH_W     = 12;
    localparam int LBP_HEIGHT_W    = 13;
    localparam int LBP_CFG_W       = 13;
    localparam int LBP_ROW_W       = 12;
    localparam int LBP_MAX_WIDTH   = 2048;
    localparam int LBP_HEIGHT_LIM  = 4096;
    localparam int LBP_RST_WIDTH   = 640;
    localparam int LBP_RST_HEIGHT  = 480;
    localparam int LBP_MIN_DIM     = 3;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // one column of the 3x3 window
    typedef struct packed {
        logic [LBP_PIX_W-1:0] top;
        logic [LBP_PIX_W-1:0] mid;
        logic [LBP_PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_gt_flags;

endpackage

// ----- design/lbp_ram.sv -----
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/lbp_cell.sv -----
module lbp_cell
    import lbp_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  t_column              i_col,
    input  logic [LBP_PIX_W-1:0] i_centre,
    output t_column              o_col,
    output t_gt_flags            o_gt
);

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_col <= '0;
        end else if (i_ctrl.shift) begin
            r_col <= i_col;
        end
    end

    assign o_col      = r_col;
    assign o_gt.top   = r_col.top > i_centre;
    assign o_gt.mid   = r_col.mid > i_centre;
    assign o_gt.bot   = r_col.bot > i_centre;

endmodule

// ----- design/lbp_3x3_texture_code.sv -----
// 3x3 local binary pattern over a raster pixel stream.
// Input channel: i_valid/o_ready with i_pixel, one grey pixel per transaction in
// raster order for a frame of frame_width x frame_height pixels.
// Output channel: o_valid/i_ready with o_pattern_code and o_frame_last, one
// transaction per interior pixel; border pixels give nothing. o_frame_last marks
// the last code of a frame, after which the position counters restart.
// Config: i_cfg_wr_en/i_cfg_index/i_cfg_wdata, to be written only while idle;
// the block does not enforce it. A write restarts the frame. Width is clamped to
// 3..MAX_WIDTH, height to 3..4096. Throughput: one pixel per clock while o_ready
// is high. The code for centre (r-1, c-1) is registered when pixel (r, c) is
// accepted; the line-store RAMs have a registered read and are read a column ahead.
// Stall: an output register plus a skid register; o_ready drops only when both
// are full, so one pixel is still taken while a result waits.
// Reset: counters, window cells and output valids clear; line stores are not
// cleared, their contents are rewritten in the first two rows of every frame.
module lbp_3x3_texture_code
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LBP_PIX_W-1:0]  i_pixel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LBP_CODE_W-1:0] o_pattern_code,
    output logic                  o_frame_last,
    input  logic                  i_cfg_wr_en,
    input  logic [0:0]            i_cfg_index,
    input  logic [LBP_CFG_W-1:0]  i_cfg_wdata
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int RST_W_EFF = (LBP_RST_WIDTH < MAX_WIDTH) ? LBP_RST_WIDTH : MAX_WIDTH;

    logic [COL_W-1:0]     r_col, n_col, r_last_col;
    logic [LBP_ROW_W-1:0] r_row, r_last_row;

    logic                  r_out_valid, r_skid_valid;
    logic [LBP_CODE_W-1:0] r_out_code, r_skid_code;
    logic                  r_out_last, r_skid_last;

    logic [LBP_WIDTH_W-1:0]  cfg_w;
    logic [LBP_HEIGHT_W-1:0] cfg_h;
    logic [COL_W-1:0]        cfg_last_col;
    logic [LBP_ROW_W-1:0]    cfg_last_row;

    logic                  accept, at_col_end, has_result, is_last, out_fire;
    logic [LBP_PIX_W-1:0]  older_rd, newer_rd, centre;
    logic [LBP_CODE_W-1:0] code;
    t_column               col_new, col_b, col_a;
    t_gt_flags             gt_a, gt_b;
    t_cell_ctrl            cell_ctrl;

    assign accept     = i_valid && o_ready;
    assign at_col_end = (r_col == r_last_col);
    assign has_result = accept && (r_row >= LBP_ROW_W'(2)) && (r_col >= COL_W'(2));
    assign is_last    = (r_row == r_last_row) && at_col_end;
    assign out_fire   = r_out_valid && i_ready;

    // clamp the written dimension and keep it as the last index
    assign cfg_w = i_cfg_wdata[LBP_WIDTH_W-1:0];
    assign cfg_h = i_cfg_wdata[LBP_HEIGHT_W-1:0];

    always_comb begin
        if (cfg_w < LBP_WIDTH_W'(LBP_MIN_DIM)) begin
            cfg_last_col = COL_W'(LBP_MIN_DIM - 1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            cfg_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = COL_W'(cfg_w - 1'b1);
        end
        if (cfg_h < LBP_HEIGHT_W'(LBP_MIN_DIM)) begin
            cfg_last_row = LBP_ROW_W'(LBP_MIN_DIM - 1);
        end else if (cfg_h > LBP_HEIGHT_W'(LBP_HEIGHT_LIM)) begin
            cfg_last_row = LBP_ROW_W'(LBP_HEIGHT_LIM - 1);
        end else begin
            cfg_last_row = LBP_ROW_W'(cfg_h - 1'b1);
        end
    end

    // next column drives the RAM read address, so data is ready on arrival
    always_comb begin
        if (!i_rst_n || i_cfg_wr_en) begin
            n_col = '0;
        end else if (accept) begin
            n_col = at_col_end ? '0 : r_col + 1'b1;
        end else begin
            n_col = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= COL_W'(RST_W_EFF - 1);
            r_last_row <= LBP_ROW_W'(LBP_RST_HEIGHT - 1);
        end else if (i_cfg_wr_en) begin
            r_col <= '0;
            r_row <= '0;
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_last_col <= cfg_last_col;
            end else begin
                r_last_row <= cfg_last_row;
            end
        end else if (accept) begin
            r_col <= n_col;
            if (at_col_end) begin
                r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
            end
        end
    end

    lbp_ram #(
        .WIDTH (LBP_PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (newer_rd),
        .i_rd_addr (n_col),
        .o_rd_data (older_rd)
    );

    lbp_ram #(
        .WIDTH (LBP_PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (i_pixel),
        .i_rd_addr (n_col),
        .o_rd_data (newer_rd)
    );

    // window: cell b holds column c-1, cell a column c-2
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = !i_rst_n || i_cfg_wr_en;
    assign col_new.top     = older_rd;
    assign col_new.mid     = newer_rd;
    assign col_new.bot     = i_pixel;
    assign centre          = col_b.mid;

    lbp_cell u_cell_b (
        .i_clk    (i_clk),
        .i_ctrl   (cell_ctrl),
        .i_col    (col_new),
        .i_centre (centre),
        .o_col    (col_b),
        .o_gt     (gt_b)
    );

    lbp_cell u_cell_a (
        .i_clk    (i_clk),
        .i_ctrl   (cell_ctrl),
        .i_col    (col_b),
        .i_centre (centre),
        .o_col    (col_a),
        .o_gt     (gt_a)
    );

    assign code = {gt_a.top, gt_b.top, older_rd > centre, newer_rd > centre,
                   i_pixel > centre, gt_b.bot, gt_a.bot, gt_a.mid};

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_code   <= r_skid_code;
                r_out_last   <= r_skid_last;
                r_skid_valid <= 1'b0;
            end
        end else if (has_result) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
                r_out_code  <= code;
                r_out_last  <= is_last;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_code  <= code;
                r_skid_last  <= is_last;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_ready        = !r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_pattern_code = r_out_code;
    assign o_frame_last   = r_out_last;

endmodule

// ----- design/lbp_checker.sv -----
module lbp_checker
    import lbp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic [LBP_PIX_W-1:0]  i_pixel,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [LBP_CODE_W-1:0] o_pattern_code,
    input logic                  o_frame_last
);

    // skid only fills while the output register is held
    a_ready_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result or stall visible after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_pattern_code) && $stable(o_frame_last))
        else $error("result changed under stall");

    // a waiting input transaction keeps its pixel
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_pixel))
        else $error("input transaction withdrawn or changed while stalled");

endmodule

bind lbp_3x3_texture_code lbp_checker u_lbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_pixel        (i_pixel),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_pattern_code (o_pattern_code),
    .o_frame_last   (o_frame_last)
);

// ----- tb/sv/lbp_3x3_texture_code_tb.sv -----
module lbp_3x3_texture_code_tb;
    import lbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int TAIL_ITEMS     = 100;

    typedef enum int {
        PIX_RANDOM,
        PIX_BAND,
        PIX_EXTREME
    } t_pix_mode;

    typedef struct packed {
        logic [LBP_CODE_W-1:0] code;
        logic                  last;
    } t_lbp_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [LBP_PIX_W-1:0]  i_pixel     = '0;
    logic                  i_ready     = 1'b1;
    logic                  i_cfg_wr_en = 1'b0;
    logic [0:0]            i_cfg_index = CFG_FRAME_WIDTH;
    logic [LBP_CFG_W-1:0]  i_cfg_wdata = '0;
    logic                  o_ready;
    logic                  o_valid;
    logic [LBP_CODE_W-1:0] o_pattern_code;
    logic                  o_frame_last;

    // predictor state
    logic [LBP_WIDTH_W-1:0]  cfg_width  = LBP_WIDTH_W'(LBP_RST_WIDTH);
    logic [LBP_HEIGHT_W-1:0] cfg_height = LBP_HEIGHT_W'(LBP_RST_HEIGHT);
    bit [LBP_PIX_W-1:0]      older_row [LBP_MAX_WIDTH];
    bit [LBP_PIX_W-1:0]      newer_row [LBP_MAX_WIDTH];
    bit [LBP_PIX_W-1:0]      win [6];
    int                      col_pos;
    int                      row_pos;
    t_lbp_result             pending_codes [$];

    // stimulus control
    int eff_w     = LBP_RST_WIDTH;
    int eff_h     = LBP_RST_HEIGHT;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int error_count = 0;
    int idle_cycles = 0;

    lbp_3x3_texture_code u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pattern_code (o_pattern_code),
        .o_frame_last   (o_frame_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < LBP_MIN_DIM) return LBP_MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_window();
        foreach (win[k]) win[k] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // advance the window by one pixel, queueing the code for an interior centre
    function automatic void step_lbp_window(input logic [LBP_PIX_W-1:0] px);
        int w;
        int h;
        int c;
        int r;
        logic [LBP_PIX_W-1:0] top;
        logic [LBP_PIX_W-1:0] mid;
        logic [LBP_PIX_W-1:0] ctr;
        t_lbp_result res;
        w = clamp_dim(int'(cfg_width), LBP_MAX_WIDTH);
        h = clamp_dim(int'(cfg_height), LBP_HEIGHT_LIM);
        c = col_pos;
        r = row_pos;
        if (c >= LBP_MAX_WIDTH) c = LBP_MAX_WIDTH - 1;
        top = older_row[c];
        mid = newer_row[c];
        if (r >= 2 && c >= 2) begin
            ctr = win[4];
            res.code = {win[0] > ctr, win[3] > ctr, top > ctr, mid > ctr,
                        px > ctr, win[5] > ctr, win[2] > ctr, win[1] > ctr};
            res.last = (r == h - 1) && (c == w - 1);
            pending_codes.push_back(res);
        end
        older_row[c] = mid;
        newer_row[c] = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = (r >= h) ? 0 : r;
        end
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    // all handshakes sampled at the edge, before any update of that edge lands
    always @(posedge i_clk) begin
        t_lbp_result want;
        if (!i_rst_n) begin
            cfg_width  = LBP_WIDTH_W'(LBP_RST_WIDTH);
            cfg_height = LBP_HEIGHT_W'(LBP_RST_HEIGHT);
            restart_window();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) cfg_width = i_cfg_wdata[LBP_WIDTH_W-1:0];
                else cfg_height = i_cfg_wdata[LBP_HEIGHT_W-1:0];
                restart_window();
            end
            if (i_valid && o_ready) step_lbp_window(i_pixel);
            if (o_valid && i_ready) begin
                if (pending_codes.size() == 0) begin
                    report_error($sformatf("result %02h/%0b with nothing pending",
                                           o_pattern_code, o_frame_last));
                end else begin
                    want = pending_codes.pop_front();
                    if (o_pattern_code !== want.code)
                        report_error($sformatf("pattern_code %02h, want %02h",
                                               o_pattern_code, want.code));
                    if (o_frame_last !== want.last)
                        report_error($sformatf("frame_last %0b, want %0b",
                                               o_frame_last, want.last));
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_wr_en || (i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_pixel(input logic [LBP_PIX_W-1:0] px);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_pixels(input int n, input t_pix_mode mode);
        int base;
        logic [LBP_PIX_W-1:0] px;
        base = $urandom_range(0, 252);
        repeat (n) begin
            case (mode)
                PIX_BAND:    px = LBP_PIX_W'(base + $urandom_range(0, 3));
                PIX_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       px = 8'h00;
                        1:       px = 8'hFF;
                        2:       px = 8'h01;
                        default: px = 8'hFE;
                    endcase
                end
                default:     px = LBP_PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(px);
        end
    endtask

    // stop sending, let every pending code drain, then allow for the pipeline
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [LBP_CFG_W-1:0] val);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [LBP_CFG_W-1:0] w_raw,
                             input logic [LBP_CFG_W-1:0] h_raw);
        write_reg(CFG_FRAME_WIDTH, w_raw);
        write_reg(CFG_FRAME_HEIGHT, h_raw);
        eff_w = clamp_dim(int'(w_raw[LBP_WIDTH_W-1:0]), LBP_MAX_WIDTH);
        eff_h = clamp_dim(int'(h_raw), LBP_HEIGHT_LIM);
    endtask

    // geometry out of reset: two rows plus a few codes of the third
    task automatic test_reset_geometry();
        send_pixels(2 * LBP_RST_WIDTH + 10, PIX_RANDOM);
        wait_idle();
    endtask

    // 3x3 frames back to back: strictness, bit order, frame wrap
    task automatic test_corner_patterns();
        logic [LBP_PIX_W-1:0] all_above [9] = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
        logic [LBP_PIX_W-1:0] all_below [9] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
        logic [LBP_PIX_W-1:0] mixed     [9] = '{128, 129, 127, 200, 128, 255, 129, 128, 0};
        configure(3, 3);
        foreach (all_above[k]) send_pixel(all_above[k]);
        foreach (all_below[k]) send_pixel(all_below[k]);
        foreach (mixed[k]) send_pixel(mixed[k]);
        wait_idle();
    endtask

    // a write part way through a frame starts a fresh one
    task automatic test_restart_mid_frame();
        configure(5, 5);
        send_pixels(13, PIX_RANDOM);
        write_reg(CFG_FRAME_WIDTH, 5);
        send_pixels(25, PIX_BAND);
        send_pixels(17, PIX_RANDOM);
        write_reg(CFG_FRAME_HEIGHT, 5);
        send_pixels(25, PIX_EXTREME);
        wait_idle();
    endtask

    task automatic test_dimension_clamp();
        configure(0, 1);
        send_pixels(eff_w * eff_h, PIX_RANDOM);
        configure(2, 2);
        send_pixels(eff_w * eff_h, PIX_BAND);
        // top bit of the write data lies outside the width register
        configure(13'h1005, 3);
        send_pixels(eff_w * eff_h, PIX_RANDOM);
        // tall frame clamped to 4096 rows: only its first rows are sent
        configure(3, 13'h1FFF);
        send_pixels(3 * 8, PIX_RANDOM);
        wait_idle();
    endtask

    task automatic run_random_frames(input int budget);
        int sent;
        int n;
        logic [LBP_CFG_W-1:0] w_raw;
        logic [LBP_CFG_W-1:0] h_raw;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0:       w_raw = LBP_CFG_W'($urandom_range(0, 2));
                1:       w_raw = LBP_CFG_W'($urandom_range(11, 40));
                default: w_raw = LBP_CFG_W'($urandom_range(3, 10));
            endcase
            case ($urandom_range(0, 19))
                0, 1:       h_raw = LBP_CFG_W'($urandom_range(0, 2));
                2, 3, 4:    h_raw = LBP_CFG_W'($urandom_range(9, 20));
                default:    h_raw = LBP_CFG_W'($urandom_range(3, 8));
            endcase
            configure(w_raw, h_raw);
            repeat ($urandom_range(1, 3)) begin
                n = eff_w * eff_h;
                // now and then a truncated frame, so the next one starts mid-stream
                if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
                if (n > budget - sent) n = budget - sent;
                send_pixels(n, t_pix_mode'($urandom_range(0, 2)));
                sent += n;
            end
        end
    endtask

    task automatic test_random_frames();
        int done_items;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            run_random_frames(200);
            done_items += 200;
        end
        wait_idle();
    endtask

    // full rate on both sides
    task automatic test_quiet_tail();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_frames(TAIL_ITEMS);
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_corner_patterns();
        test_restart_mid_frame();
        test_dimension_clamp();
        test_random_frames();
        test_quiet_tail();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_codes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lbp_pkg.sv
design/lbp_ram.sv
design/lbp_cell.sv
design/lbp_3x3_texture_code.sv
design/lbp_checker.sv
tb/sv/lbp_3x3_texture_code_tb.sv
